[hw/rtl/npcm_pkg.sv]
// Shared types, constants and the channel quantization table for the
// nearest palette color mapper. No dependencies.
package npcm_pkg;

    // Default palette depth handed to the top level.
    localparam int PAL_ENTRIES_DEF = 256;

    // Fixed field widths.
    localparam int CH_W      = 8;
    localparam int IDX_IN_W  = 8;
    localparam int PIX_W     = 15;
    localparam int IN_DATA_W = 32;
    localparam int OUT_DATA_W = 16;
    localparam int DIST_W    = 18;
    localparam int SQ_W      = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 1;

    // The running best distance starts above any reachable distance.
    localparam logic [DIST_W-1:0] DIST_START = 18'h30001;

    // Item kinds carried on tuser.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANT  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_wr;    // write black at the sweep address
        logic load_wr;     // write the accepted load item into the palette
        logic capture;     // latch the accepted query color, restart the search
        logic rd_en;       // read the palette at the sweep address
        logic result_load; // move the finished result into the output register
    } t_npcm_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic direct_mode;   // direct 5:5:5 packing is selected
        logic search_busy;   // distance pipeline still holds entries
    } t_npcm_sts;

    // Top 3 bits of a channel expanded as q*255/7 with integer division.
    function automatic logic [CH_W-1:0] quantize_channel(input logic [CH_W-1:0] v);
        logic [CH_W-1:0] q;
        case (v[CH_W-1 -: 3])
            3'd0:    q = 8'd0;
            3'd1:    q = 8'd36;
            3'd2:    q = 8'd72;
            3'd3:    q = 8'd109;
            3'd4:    q = 8'd145;
            3'd5:    q = 8'd182;
            3'd6:    q = 8'd218;
            3'd7:    q = 8'd255;
            default: q = 8'd0;
        endcase
        return q;
    endfunction

endpackage

[hw/rtl/nearest_palette_color_mapper_core.sv]
// A direct-mode query goes from capture through the drain state to the output register;
// an indexed one first reads each palette entry, one per cycle, and the three-stage
// read, square and compare pipeline drains. The result waits for a free output register.
// A load leaves the controller ready for the next transaction; a new query is taken only
// once the previous one is through. Reset (synchronous, active low) starts a clear sweep
// that writes black to every entry; no input transaction is accepted meanwhile.
module nearest_palette_color_mapper_core
    import npcm_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PAL_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // Configuration writes: index 0 selects direct color mode,
    // index 1 enables query quantization.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    // Input stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // entry_index, red, green, blue
    input  logic                  s_axis_tuser,  // kind

    // Result stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // pixel_value, one zero pad bit
);

    localparam int IDX_W = $clog2(PALETTE_ENTRIES);

    t_npcm_cmd        cmd;
    t_npcm_sts        sts;
    logic [IDX_W-1:0] addr;
    logic [PIX_W-1:0] pixel;

    // The controller accepts one transaction at a time. A load is written in
    // its acceptance cycle. A query is captured; in indexed mode the controller
    // sweeps every palette address while the datapath keeps the first entry
    // with the least squared distance. The result waits in an output register,
    // so loads and a following query are taken while a result is still pending;
    // the query only stalls at hand-off if the previous result is still there.
    npcm_ctrl #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_kind  (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_addr     (addr)
    );

    // The datapath holds the palette, the configuration registers, the
    // distance pipeline and the result register.
    npcm_datapath #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .i_addr     (addr),
        .i_in_data  (s_axis_tdata),
        .o_sts      (sts),
        .o_pixel    (pixel)
    );

    assign m_axis_tdata = {1'b0, pixel};

endmodule

[hw/rtl/npcm_ctrl.sv]
// Controller state machine of the nearest palette color mapper.
// Sequences the clear sweep, loads, the palette search and result hand-off.
// Depends on npcm_pkg.
module npcm_ctrl
    import npcm_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PAL_ENTRIES_DEF,
    localparam int IDX_W = $clog2(PALETTE_ENTRIES)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_kind,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  t_npcm_sts        i_sts,
    output t_npcm_cmd        o_cmd,
    output logic [IDX_W-1:0] o_addr
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEARCH,
        ST_DRAIN
    } t_state;

    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(PALETTE_ENTRIES - 1);

    t_state           r_state;
    logic [IDX_W-1:0] r_cnt;
    logic             r_out_vld;

    logic in_acc;
    logic out_free;

    assign in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_vld || i_out_ready;

    always_comb begin
        o_cmd             = '0;
        o_cmd.clear_wr    = (r_state == ST_CLEAR);
        o_cmd.rd_en       = (r_state == ST_SEARCH);
        o_cmd.load_wr     = in_acc && (i_in_kind == KIND_LOAD);
        o_cmd.capture     = in_acc && (i_in_kind == KIND_QUERY);
        o_cmd.result_load = (r_state == ST_DRAIN) && !i_sts.search_busy && out_free;
    end

    assign o_addr      = r_cnt;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_cmd.result_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                ST_CLEAR: begin
                    if (r_cnt == LAST_ADDR) begin
                        r_cnt   <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (o_cmd.capture) begin
                        r_cnt   <= '0;
                        r_state <= i_sts.direct_mode ? ST_DRAIN : ST_SEARCH;
                    end
                end
                ST_SEARCH: begin
                    if (r_cnt == LAST_ADDR) begin
                        r_cnt   <= '0;
                        r_state <= ST_DRAIN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    if (o_cmd.result_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // A new result must never overwrite one that is still waiting downstream.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.result_load |-> (!r_out_vld || i_out_ready))
        else $error("result loaded over a pending output transaction");

    // An output transaction only appears right after the drain state hands off.
    a_valid_from_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == ST_DRAIN))
        else $error("output valid raised outside the drain hand-off");

    // The sweep counter never runs past the last palette address.
    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= LAST_ADDR)
        else $error("sweep counter beyond the last palette address");

endmodule

[hw/rtl/npcm_datapath.sv]
// Datapath of the nearest palette color mapper: configuration registers,
// palette memory, three-stage distance pipeline and result register.
// Depends on npcm_pkg.
module npcm_datapath
    import npcm_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PAL_ENTRIES_DEF,
    localparam int IDX_W = $clog2(PALETTE_ENTRIES)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_npcm_cmd             i_cmd,
    input  logic [IDX_W-1:0]      i_addr,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    output t_npcm_sts             o_sts,
    output logic [PIX_W-1:0]      o_pixel
);

    localparam int ADDR_EXT_W = (IDX_W > IDX_IN_W) ? IDX_W : IDX_IN_W;

    logic [3*CH_W-1:0] r_mem [PALETTE_ENTRIES];

    logic r_direct;
    logic r_quant;

    logic [CH_W-1:0] r_qr, r_qg, r_qb;

    logic              r_rd_vld;
    logic [IDX_W-1:0]  r_rd_idx;
    logic [3*CH_W-1:0] r_rd_data;

    logic              r_sq_vld;
    logic [IDX_W-1:0]  r_sq_idx;
    logic [SQ_W-1:0]   r_sq_r, r_sq_g, r_sq_b;

    logic [DIST_W-1:0] r_best_dist;
    logic [IDX_W-1:0]  r_best_idx;
    logic [PIX_W-1:0]  r_pixel;

    logic [IDX_IN_W-1:0] in_idx;
    logic [CH_W-1:0]     in_r, in_g, in_b;
    logic [ADDR_EXT_W-1:0] in_idx_ext;
    logic                load_ok;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [3*CH_W-1:0]   mem_wdata;
    logic                quant_now;

    logic [CH_W-1:0] pal_r, pal_g, pal_b;
    logic [CH_W-1:0] d_r, d_g, d_b;
    logic [DIST_W-1:0] sum_dist;
    logic [PIX_W-1:0]  packed_pix;

    // Input tdata, lowest bits first: entry_index, red, green, blue.
    assign in_idx = i_in_data[7:0];
    assign in_r   = i_in_data[15:8];
    assign in_g   = i_in_data[23:16];
    assign in_b   = i_in_data[31:24];

    // Loads beyond the palette depth are dropped.
    assign in_idx_ext = ADDR_EXT_W'(in_idx);
    assign load_ok    = (32'(in_idx) < PALETTE_ENTRIES);

    assign mem_we    = i_cmd.clear_wr || (i_cmd.load_wr && load_ok);
    assign mem_waddr = i_cmd.clear_wr ? i_addr : in_idx_ext[IDX_W-1:0];
    assign mem_wdata = i_cmd.clear_wr ? '0 : {in_b, in_g, in_r};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direct <= 1'b0;
            r_quant  <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DIRECT: r_direct <= i_cfg_data[0];
                CFG_QUANT:  r_quant  <= i_cfg_data[0];
                default:    ;
            endcase
        end
    end

    // Quantization only applies to palette searches.
    assign quant_now = r_quant && !r_direct;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_qr <= quant_now ? quantize_channel(in_r) : in_r;
            r_qg <= quant_now ? quantize_channel(in_g) : in_g;
            r_qb <= quant_now ? quantize_channel(in_b) : in_b;
        end
    end

    // Stage 2: absolute channel differences squared.
    assign pal_r = r_rd_data[7:0];
    assign pal_g = r_rd_data[15:8];
    assign pal_b = r_rd_data[23:16];
    assign d_r   = (r_qr > pal_r) ? (r_qr - pal_r) : (pal_r - r_qr);
    assign d_g   = (r_qg > pal_g) ? (r_qg - pal_g) : (pal_g - r_qg);
    assign d_b   = (r_qb > pal_b) ? (r_qb - pal_b) : (pal_b - r_qb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_sq_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            r_sq_vld <= r_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= i_addr;
        r_sq_idx <= r_rd_idx;
        r_sq_r   <= SQ_W'(d_r) * SQ_W'(d_r);
        r_sq_g   <= SQ_W'(d_g) * SQ_W'(d_g);
        r_sq_b   <= SQ_W'(d_b) * SQ_W'(d_b);
    end

    // Stage 3: sum and keep the first strict minimum.
    assign sum_dist = DIST_W'(r_sq_r) + DIST_W'(r_sq_g) + DIST_W'(r_sq_b);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_best_dist <= DIST_START;
            r_best_idx  <= '0;
        end else if (r_sq_vld && (sum_dist < r_best_dist)) begin
            r_best_dist <= sum_dist;
            r_best_idx  <= r_sq_idx;
        end
    end

    assign packed_pix = {r_qr[7:3], r_qg[7:3], r_qb[7:3]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.result_load) begin
            r_pixel <= r_direct ? packed_pix : PIX_W'(r_best_idx);
        end
    end

    assign o_pixel           = r_pixel;
    assign o_sts.direct_mode = r_direct;
    assign o_sts.search_busy = r_rd_vld || r_sq_vld;

    // The result must only be taken once the distance pipeline has emptied.
    a_result_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.result_load |-> !(r_rd_vld || r_sq_vld))
        else $error("result taken while the distance pipeline is busy");

    // The clear sweep and a load never compete for the write port.
    a_single_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.clear_wr && i_cmd.load_wr))
        else $error("clear sweep and palette load in the same cycle");

    // Squared terms only follow a palette read in the cycle before.
    a_sq_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq_vld |-> $past(r_rd_vld))
        else $error("squared terms without a preceding palette read");

endmodule
